// ----- design/text_tokenizer_inverted_index_defines.svh -----
// Assertion macros shared by the inverted index RTL.
`ifndef TEXT_TOKENIZER_INVERTED_INDEX_DEFINES_SVH
`define TEXT_TOKENIZER_INVERTED_INDEX_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define TTI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define TTI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/tti_pkg.sv -----
// Package: shared types and defaults of the inverted index builder.
`default_nettype none
package tti_pkg;

  localparam int TERM_SLOTS_DEF        = 1024;
  localparam int WORD_LEN_DEF          = 32;
  localparam int POSTINGS_PER_TERM_DEF = 16;

  typedef enum logic [1:0] {
    ST_ADDED      = 2'd0,
    ST_DUP        = 2'd1,
    ST_TABLE_FULL = 2'd2,
    ST_POST_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0]  text_byte;
    logic [15:0] doc_id;
    logic        end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  term_id;
    status_t     status;
    logic [4:0]  doc_freq;
    logic [10:0] unique_terms;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CNT,
    S_DUP,
    S_APPEND
  } bk_state_t;

endpackage
`default_nettype wire

// ----- design/tti_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tti_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ----- design/tti_front.sv -----
// Tokenizer front: lowercases bytes into the word buffer and emits completed words.
`default_nettype none
module tti_front #(
  parameter int WORD_LEN = tti_pkg::WORD_LEN_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_take,
  input  wire tti_pkg::in_item_t            in_item,
  output logic                              push,
  output logic [16+WORD_LEN*8-1:0]          push_data
);

  localparam int LW = $clog2(WORD_LEN);
  localparam logic [LW-1:0] LEN_MAX = LW'(WORD_LEN - 1);

  logic [7:0]    buf_r   [WORD_LEN];
  logic [7:0]    buf_nxt [WORD_LEN];
  logic [LW-1:0] len_r, len_nxt, len_add, len_eff;
  logic [7:0]    b, low_b;
  logic          is_low, is_up, is_dig, alnum, wr;
  logic [WORD_LEN*8-1:0] text;

  assign b      = in_item.text_byte;
  assign is_low = (b >= 8'h61) && (b <= 8'h7a);
  assign is_up  = (b >= 8'h41) && (b <= 8'h5a);
  assign is_dig = (b >= 8'h30) && (b <= 8'h39);
  assign alnum  = is_low || is_up || is_dig;
  assign low_b  = is_up ? (b + 8'd32) : b;
  assign wr     = alnum && (len_r != LEN_MAX);
  assign len_add = wr ? (len_r + LW'(1)) : len_r;
  assign len_eff = alnum ? len_add : len_r;

  always_comb begin
    buf_nxt = buf_r;
    if (in_take && wr) begin
      buf_nxt[len_r] = low_b;
    end
  end

  always_comb begin
    len_nxt = len_r;
    if (in_take) begin
      len_nxt = (alnum && !in_item.end_of_text) ? len_add : '0;
    end
  end

  // bytes past the word end are zeroed so stored rows compare whole
  always_comb begin
    for (int k = 0; k < WORD_LEN; k++) begin
      text[k*8 +: 8] = ((LW+1)'(k) < {1'b0, len_eff}) ? buf_nxt[k] : 8'h00;
    end
  end

  assign push = in_take && ((alnum && in_item.end_of_text) || (!alnum && (len_r != '0)));
  assign push_data = {in_item.doc_id, text};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else begin
      len_r <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

endmodule
`default_nettype wire

// ----- design/tti_queue.sv -----
// Two-entry word queue between tokenizer and index engine.
`default_nettype none
`include "text_tokenizer_inverted_index_defines.svh"
module tti_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] din,
  input  wire logic         pop,
  output logic              full,
  output logic              empty,
  output logic [W-1:0]      dout
);

  logic [W-1:0] mem_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign dout  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

  `TTI_ASSERT_IMP(a_q_no_overflow, push, !full || pop, "queue push while full")
  `TTI_ASSERT_IMP(a_q_no_underflow, pop, !empty, "queue pop while empty")

endmodule
`default_nettype wire

// ----- design/tti_back.sv -----
// Index engine: term table search, insert and postings update per word.
`default_nettype none
`include "text_tokenizer_inverted_index_defines.svh"
module tti_back #(
  parameter int TERM_SLOTS        = tti_pkg::TERM_SLOTS_DEF,
  parameter int WORD_LEN          = tti_pkg::WORD_LEN_DEF,
  parameter int POSTINGS_PER_TERM = tti_pkg::POSTINGS_PER_TERM_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        q_empty,
  input  wire logic [16+WORD_LEN*8-1:0]    q_data,
  output logic                             pop,
  output logic                             out_valid,
  output tti_pkg::out_item_t               out_item
);

  localparam int SW  = $clog2(TERM_SLOTS);
  localparam int CW  = $clog2(POSTINGS_PER_TERM + 1);
  localparam int PAW = $clog2(TERM_SLOTS * POSTINGS_PER_TERM);
  localparam int TW  = WORD_LEN * 8;
  localparam logic [SW:0]    SLOTS_V = (SW+1)'(TERM_SLOTS);
  localparam logic [CW-1:0]  POST_V  = CW'(POSTINGS_PER_TERM);
  localparam logic [PAW-1:0] POST_A  = PAW'(POSTINGS_PER_TERM);

  tti_pkg::bk_state_t state_r, state_nxt;

  logic [TW-1:0]   word_r, word_nxt;
  logic [15:0]     doc_r, doc_nxt;
  logic [SW:0]     total_r, total_nxt;
  logic [SW:0]     rd_idx_r, rd_idx_nxt;
  logic            pend_r, pend_nxt;
  logic [SW-1:0]   pend_idx_r, pend_idx_nxt;
  logic [SW-1:0]   slot_r, slot_nxt;
  logic [PAW-1:0]  base_r, base_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt, j_r, j_nxt;
  logic            out_valid_r, out_valid_nxt;
  tti_pkg::out_item_t out_item_r, out_item_nxt;

  logic            term_we, cnt_we, post_we;
  logic [SW-1:0]   term_waddr, term_raddr, cnt_waddr, cnt_raddr;
  logic [TW-1:0]   term_rdata;
  logic [CW-1:0]   cnt_wdata, cnt_rdata;
  logic [PAW-1:0]  post_waddr, post_raddr;
  logic [15:0]     post_rdata;

  logic            hit, scan_end, dup_hit, dup_end, table_full, post_full;
  logic [31:0]     tid_w, df_w, ut_w;

  tti_ram #(.WIDTH(TW), .DEPTH(TERM_SLOTS)) u_term (
    .clk(clk), .we(term_we), .waddr(term_waddr), .wdata(word_r),
    .raddr(term_raddr), .rdata(term_rdata)
  );

  tti_ram #(.WIDTH(CW), .DEPTH(TERM_SLOTS)) u_cnt (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_rdata)
  );

  tti_ram #(.WIDTH(16), .DEPTH(TERM_SLOTS * POSTINGS_PER_TERM)) u_post (
    .clk(clk), .we(post_we), .waddr(post_waddr), .wdata(doc_r),
    .raddr(post_raddr), .rdata(post_rdata)
  );

  // pend_r marks a read issued last cycle whose data is on the RAM output now
  assign hit        = pend_r && (term_rdata == word_r);
  assign scan_end   = !pend_r && (rd_idx_r >= total_r);
  assign dup_hit    = pend_r && (post_rdata == doc_r);
  assign dup_end    = !pend_r && (j_r >= cnt_r);
  assign table_full = (total_r == SLOTS_V);
  assign post_full  = (cnt_r >= POST_V);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tti_pkg::S_IDLE: begin
        if (!q_empty) state_nxt = tti_pkg::S_SCAN;
      end
      tti_pkg::S_SCAN: begin
        if (hit) begin
          state_nxt = tti_pkg::S_CNT;
        end else if (scan_end) begin
          state_nxt = table_full ? tti_pkg::S_IDLE : tti_pkg::S_APPEND;
        end
      end
      tti_pkg::S_CNT: state_nxt = tti_pkg::S_DUP;
      tti_pkg::S_DUP: begin
        if (dup_hit) begin
          state_nxt = tti_pkg::S_IDLE;
        end else if (dup_end) begin
          state_nxt = tti_pkg::S_APPEND;
        end
      end
      tti_pkg::S_APPEND: state_nxt = tti_pkg::S_IDLE;
      default: state_nxt = tti_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    pop           = 1'b0;
    word_nxt      = word_r;
    doc_nxt       = doc_r;
    total_nxt     = total_r;
    rd_idx_nxt    = rd_idx_r;
    pend_nxt      = 1'b0;
    pend_idx_nxt  = pend_idx_r;
    slot_nxt      = slot_r;
    base_nxt      = base_r;
    cnt_nxt       = cnt_r;
    j_nxt         = j_r;
    term_we       = 1'b0;
    term_waddr    = total_r[SW-1:0];
    term_raddr    = rd_idx_r[SW-1:0];
    cnt_we        = 1'b0;
    cnt_waddr     = slot_r;
    cnt_wdata     = cnt_r + CW'(1);
    cnt_raddr     = pend_idx_r;
    post_we       = 1'b0;
    post_waddr    = base_r + PAW'(cnt_r);
    post_raddr    = base_r + PAW'(j_r);
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    tid_w         = 32'(slot_r);
    df_w          = 32'(cnt_r);
    ut_w          = 32'(total_r);
    case (state_r)
      tti_pkg::S_IDLE: begin
        if (!q_empty) begin
          pop        = 1'b1;
          word_nxt   = q_data[TW-1:0];
          doc_nxt    = q_data[TW +: 16];
          rd_idx_nxt = '0;
        end
      end
      tti_pkg::S_SCAN: begin
        if (rd_idx_r < total_r) begin
          rd_idx_nxt   = rd_idx_r + (SW+1)'(1);
          pend_nxt     = 1'b1;
          pend_idx_nxt = rd_idx_r[SW-1:0];
        end
        if (hit) begin
          slot_nxt = pend_idx_r;
          base_nxt = PAW'(pend_idx_r) * POST_A;
        end else if (scan_end) begin
          if (table_full) begin
            out_valid_nxt             = 1'b1;
            out_item_nxt.term_id      = '0;
            out_item_nxt.status       = tti_pkg::ST_TABLE_FULL;
            out_item_nxt.doc_freq     = '0;
            out_item_nxt.unique_terms = ut_w[10:0];
          end else begin
            term_we   = 1'b1;
            slot_nxt  = total_r[SW-1:0];
            base_nxt  = PAW'(total_r[SW-1:0]) * POST_A;
            cnt_nxt   = '0;
            total_nxt = total_r + (SW+1)'(1);
          end
        end
      end
      tti_pkg::S_CNT: begin
        cnt_nxt = cnt_rdata;
        j_nxt   = '0;
      end
      tti_pkg::S_DUP: begin
        if (j_r < cnt_r) begin
          j_nxt    = j_r + CW'(1);
          pend_nxt = 1'b1;
        end
        if (dup_hit) begin
          out_valid_nxt             = 1'b1;
          out_item_nxt.term_id      = tid_w[9:0];
          out_item_nxt.status       = tti_pkg::ST_DUP;
          out_item_nxt.doc_freq     = df_w[4:0];
          out_item_nxt.unique_terms = ut_w[10:0];
        end
      end
      tti_pkg::S_APPEND: begin
        out_valid_nxt             = 1'b1;
        out_item_nxt.term_id      = tid_w[9:0];
        out_item_nxt.unique_terms = ut_w[10:0];
        if (post_full) begin
          out_item_nxt.status   = tti_pkg::ST_POST_FULL;
          out_item_nxt.doc_freq = df_w[4:0];
        end else begin
          post_we  = 1'b1;
          cnt_we   = 1'b1;
          cnt_nxt  = cnt_r + CW'(1);
          df_w     = 32'(cnt_nxt);
          out_item_nxt.status   = tti_pkg::ST_ADDED;
          out_item_nxt.doc_freq = df_w[4:0];
        end
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tti_pkg::S_IDLE;
      total_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r     <= word_nxt;
    doc_r      <= doc_nxt;
    rd_idx_r   <= rd_idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    slot_r     <= slot_nxt;
    base_r     <= base_nxt;
    cnt_r      <= cnt_nxt;
    j_r        <= j_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `TTI_ASSERT_IMP(a_total_max, 1'b1, total_r <= SLOTS_V, "term count past table size")
  `TTI_ASSERT_IMP(a_scan_in_range, (state_r == tti_pkg::S_SCAN) && pend_r, {1'b0, pend_idx_r} < total_r, "scan read past last term")
  `TTI_ASSERT_IMP(a_pop_idle, pop, state_r == tti_pkg::S_IDLE, "word taken while engine busy")

endmodule
`default_nettype wire

// ----- design/text_tokenizer_inverted_index.sv -----
// Top level of the inverted index builder: tokenizer, word queue, index engine.
`default_nettype none
// Text bytes are taken one per cycle on start while busy is low; busy rises
// only when the two-entry word queue is full. Each completed word is handled
// by the index engine, which scans the term table one row per cycle out of
// the term RAM after taking the word from the queue. A new term goes from the
// scan straight to the append state, or reports table full when no slot is
// left. A known term fetches its id count and scans the postings RAM for a
// repeated id, which reports at once when found; otherwise it goes on to
// append and report (postings full when the list is at its cap). The term
// table scan sets the per-word cost. Each result shows on out_item for
// exactly one cycle with out_valid high and must be captured then; the
// receiver cannot stall it. A result is one per completed word, in word
// order: the slot of the term, a status (added, repeated id, table full,
// postings full), the id count of the term and the number of distinct terms.
// Stored table and postings contents need no clearing after reset; of the
// index contents only the term count is reset.
module text_tokenizer_inverted_index #(
  parameter int TERM_SLOTS        = tti_pkg::TERM_SLOTS_DEF,
  parameter int WORD_LEN          = tti_pkg::WORD_LEN_DEF,
  parameter int POSTINGS_PER_TERM = tti_pkg::POSTINGS_PER_TERM_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire tti_pkg::in_item_t   in_item,
  output logic                     out_valid,
  output tti_pkg::out_item_t       out_item
);

  localparam int QW = 16 + WORD_LEN * 8;

  logic          in_take;
  logic          q_push, q_pop, q_full, q_empty;
  logic [QW-1:0] q_din, q_dout;

  // a request is taken whenever the queue has room for a possible word
  assign busy    = q_full;
  assign in_take = start && !busy;

  tti_front #(.WORD_LEN(WORD_LEN)) u_front (
    .clk(clk), .rst_n(rst_n), .in_take(in_take), .in_item(in_item),
    .push(q_push), .push_data(q_din)
  );

  tti_queue #(.W(QW)) u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .din(q_din), .pop(q_pop),
    .full(q_full), .empty(q_empty), .dout(q_dout)
  );

  tti_back #(
    .TERM_SLOTS(TERM_SLOTS), .WORD_LEN(WORD_LEN),
    .POSTINGS_PER_TERM(POSTINGS_PER_TERM)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_data(q_dout), .pop(q_pop),
    .out_valid(out_valid), .out_item(out_item)
  );

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the inverted index builder top level.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS     = tti_pkg::TERM_SLOTS_DEF;
  localparam int WLEN      = tti_pkg::WORD_LEN_DEF;
  localparam int POST_CAP  = tti_pkg::POSTINGS_PER_TERM_DEF;
  localparam int TAIL_WAIT = 3 * SLOTS + 100;  // worst word: full scan + postings scan

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  tti_pkg::in_item_t  in_item = '0;
  logic               busy;
  logic               out_valid;
  tti_pkg::out_item_t out_item;

  text_tokenizer_inverted_index dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Index predictor: shadow term table, postings lists and word buffer.
  // ---------------------------------------------------------------------
  int                 slot_of_term[string];    // term text -> table slot
  int                 n_terms = 0;
  logic [15:0]        doc_list[SLOTS][$];      // postings per slot
  string              pending_word = "";
  tti_pkg::out_item_t expected_q[$];           // results still owed by the block
  int                 errors = 0;
  int                 sent = 0;
  bit                 allow_gaps = 1'b1;

  function automatic bit is_alnum(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || (b >= "0" && b <= "9");
  endfunction

  // Close the pending word and queue the result it must produce.
  function automatic void close_word(logic [15:0] doc);
    tti_pkg::out_item_t r;
    int                 slot;
    bit                 dup;
    r = '0;
    if (slot_of_term.exists(pending_word)) begin
      slot = slot_of_term[pending_word];
    end else if (n_terms >= SLOTS) begin
      r.term_id      = '0;
      r.status       = tti_pkg::ST_TABLE_FULL;
      r.doc_freq     = '0;
      r.unique_terms = 11'(n_terms);
      expected_q.push_back(r);
      pending_word = "";
      return;
    end else begin
      slot = n_terms;
      slot_of_term[pending_word] = slot;
      doc_list[slot].delete();
      n_terms++;
    end
    dup = 1'b0;
    foreach (doc_list[slot][i]) if (doc_list[slot][i] == doc) dup = 1'b1;
    r.term_id = 10'(slot);
    if (dup) begin
      r.status = tti_pkg::ST_DUP;
    end else if (doc_list[slot].size() >= POST_CAP) begin
      r.status = tti_pkg::ST_POST_FULL;
    end else begin
      doc_list[slot].push_back(doc);
      r.status = tti_pkg::ST_ADDED;
    end
    r.doc_freq     = 5'(doc_list[slot].size());
    r.unique_terms = 11'(n_terms);
    expected_q.push_back(r);
    pending_word = "";
  endfunction

  function automatic void predict_byte(tti_pkg::in_item_t it);
    logic [7:0] c;
    if (is_alnum(it.text_byte)) begin
      if (pending_word.len() < WLEN - 1) begin
        c = (it.text_byte >= "A" && it.text_byte <= "Z") ? it.text_byte + 8'd32 : it.text_byte;
        pending_word = {pending_word, " "};
        pending_word.putc(pending_word.len() - 1, c);
      end
      if (it.end_of_text) close_word(it.doc_id);
    end else if (pending_word.len() > 0) begin
      close_word(it.doc_id);
    end
  endfunction

  // ---------------------------------------------------------------------
  // Request driver: start stays high across back-to-back requests and is
  // only dropped for a random gap or when the stream pauses.
  // ---------------------------------------------------------------------
  task automatic send_byte(logic [7:0] b, logic [15:0] doc, logic eot);
    tti_pkg::in_item_t it;
    it.text_byte   = b;
    it.doc_id      = doc;
    it.end_of_text = eot;
    if (allow_gaps && $urandom_range(99) < 9) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_item <= it;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_byte(it);
    sent++;
  endtask

  task automatic send_text(string s, logic [15:0] doc);
    for (int i = 0; i < s.len(); i++) send_byte(s.getc(i), doc, 1'b0);
  endtask

  // ---------------------------------------------------------------------
  // Result checker: the block cannot be stalled, so every strobe counts.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    tti_pkg::out_item_t e;
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result term_id=%0d status=%0d doc_freq=%0d unique=%0d",
                 $time, out_item.term_id, out_item.status, out_item.doc_freq,
                 out_item.unique_terms);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_item.term_id !== e.term_id) begin
          $display("%0t: term_id expected %0d actual %0d", $time, e.term_id, out_item.term_id);
          errors++;
        end
        if (out_item.status !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, out_item.status);
          errors++;
        end
        if (out_item.doc_freq !== e.doc_freq) begin
          $display("%0t: doc_freq expected %0d actual %0d", $time, e.doc_freq,
                   out_item.doc_freq);
          errors++;
        end
        if (out_item.unique_terms !== e.unique_terms) begin
          $display("%0t: unique_terms expected %0d actual %0d", $time, e.unique_terms,
                   out_item.unique_terms);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Case folding, dup ids, ids at both extremes, zero and 0xFF separators.
  task automatic test_basic_words();
    send_text("Ab9", 16'h0000);
    send_byte(8'h00, 16'h0000, 1'b0);         // zero byte is a separator
    send_text("aB9", 16'h0000);
    send_byte(8'hFF, 16'h0000, 1'b0);         // same term, same id: dup
    send_text("ZZ", 16'hFFFF);
    send_byte(" ", 16'hFFFF, 1'b1);           // separator carrying end mark
    send_byte("z", 16'h5A5A, 1'b1);           // end mark on a letter flushes
    send_byte(".", 16'h5A5A, 1'b1);           // nothing pending: no result
  endtask

  // Overlong word is cut; a word spanning ids lands under the closing id.
  task automatic test_truncation_and_span();
    for (int i = 0; i < WLEN + 6; i++) send_byte("a" + 8'(i % 26), 16'h0001, 1'b0);
    send_byte(",", 16'h0002, 1'b0);
    send_text("sp", 16'h0003);
    send_text("an", 16'hA5A5);
    send_byte("!", 16'h1234, 1'b0);
  endtask

  // One term collects ids past its postings cap; dup check precedes cap.
  task automatic test_postings_cap();
    for (int d = 0; d < POST_CAP + 2; d++) send_byte("p", 16'(d + 100), 1'b1);
    send_byte("p", 16'd100, 1'b1);
  endtask

  function automatic logic [7:0] random_separator();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (is_alnum(b));
    return b;
  endfunction

  // Mostly well-formed words from a small vocabulary, plus raw noise.
  task automatic test_random_traffic(int n_items);
    string       alphabet = "abcdABCD01";
    logic [15:0] doc;
    int          wlen;
    int          stop_at;
    stop_at = sent + n_items;
    while (sent < stop_at) begin
      doc = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(23) * 2731);
      if ($urandom_range(99) < 8) begin
        send_byte(8'($urandom), 16'($urandom), 1'($urandom));
      end else begin
        wlen = ($urandom_range(49) == 0) ? $urandom_range(WLEN - 2, WLEN + 8)
                                         : $urandom_range(1, 3);
        for (int i = 0; i < wlen; i++)
          send_byte(alphabet.getc($urandom_range(alphabet.len() - 1)), doc,
                    (i == wlen - 1) && ($urandom_range(4) == 0));
        if (pending_word.len() > 0) send_byte(random_separator(), doc, 1'($urandom));
      end
    end
  endtask

  // Fill the table with one- and two-character terms closed by the end mark,
  // with a long stretch of unbroken requests, then overflow it and revisit
  // old terms.
  task automatic test_table_full();
    string chars;
    string w;
    int    k;
    int    hi;
    int    lo;
    chars = "abcdefghijklmnopqrstuvwxyz0123456789";
    k = 0;
    while (n_terms < SLOTS) begin
      allow_gaps = !(k >= 300 && k < 700);
      if (k < chars.len()) begin
        w = chars.substr(k, k);
      end else begin
        hi = (k - chars.len()) / chars.len();
        lo = (k - chars.len()) % chars.len();
        w  = {chars.substr(hi, hi), chars.substr(lo, lo)};
      end
      k++;
      if (!slot_of_term.exists(w)) begin
        if ($urandom_range(1) == 0) w = w.toupper();
        for (int i = 0; i < w.len() - 1; i++) send_byte(w.getc(i), 16'd7, 1'b0);
        send_byte(w.getc(w.len() - 1), 16'($urandom_range(3)), 1'b1);
      end
    end
    allow_gaps = 1'b1;
    for (int i = 0; i < 4; i++) begin
      send_text($sformatf("ovf%0d", i), 16'($urandom));
      send_byte("-", 16'($urandom), 1'b1);
    end
    send_text("ab9", 16'hFFFF);
    send_byte(8'h80, 16'h00FF, 1'b0);
    send_text("zz", 16'h7FFF);
    send_byte(8'h7F, 16'h7FFF, 1'b0);
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_words();
    test_truncation_and_span();
    test_postings_cap();
    test_random_traffic(200);
    test_table_full();
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);   // nothing further may show up
    if (expected_q.size() != 0) errors++;
    if (errors == 0) begin
      $display("text_tokenizer_inverted_index regression: pass");
    end else begin
      $display("text_tokenizer_inverted_index regression: fail");
    end
    $finish;
  end

  // Watchdog: table fill and full-table scans dominate the run time.
  initial begin
    #100_000_000;
    $display("text_tokenizer_inverted_index regression: fail");
    $finish;
  end

endmodule
`default_nettype wire

// ----- filelist.f -----
+incdir+design
design/tti_pkg.sv
design/tti_ram.sv
design/tti_front.sv
design/tti_queue.sv
design/tti_back.sv
design/text_tokenizer_inverted_index.sv
tb/tb_top.sv
